// ===== rtl/rsa_pkg.sv =====
// shared widths for the rational sum accumulator
package rsa_pkg;

    localparam int NUM_W      = 32;  // numerator field width
    localparam int DEN_W      = 31;  // denominator field width
    localparam int WIDE_W     = 64;  // exact sum and product width
    localparam int SHIFT_W    = $clog2(WIDE_W);
    localparam int VALUE_W_DEF = 32;

endpackage

// ===== rtl/rational_sum_accumulator_unit.sv =====
// rational sum accumulator: sequencer, running sum and result register
// one item at a time: multiplies (later items only), then a binary gcd whose
// length depends on the operands, then a numerator and a denominator divide;
// a zero denominator skips all of these steps, a zero sum skips the gcd and divides
// next item taken on return to idle; the result register lets it start while one waits
// reset: sum 0/1, no list open, output empty
module rational_sum_accumulator_unit
    import rsa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [NUM_W-1:0] addend_numerator,
    input  logic [DEN_W-1:0]        addend_denominator,
    input  logic                    last_element,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [NUM_W-1:0] sum_numerator,
    output logic [DEN_W-1:0]        sum_denominator,
    output logic                    overflow,
    output logic                    is_final
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_MAG  = 4'd4;
    localparam logic [3:0] S_GO   = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DIVN = 4'd7;
    localparam logic [3:0] S_DIVD = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic [WIDE_W-1:0] LIM     = WIDE_W'(1) << (VALUE_WIDTH - 1);
    localparam logic [WIDE_W-1:0] LIM_MAX = LIM - WIDE_W'(1);

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic signed [VALUE_WIDTH-1:0] acc_num_reg;
    logic [VALUE_WIDTH-2:0]        acc_den_reg;
    logic                          list_started_reg;

    logic                    out_valid_reg;
    logic signed [NUM_W-1:0] out_num_reg;
    logic [DEN_W-1:0]        out_den_reg;
    logic                    out_ovf_reg;
    logic                    out_final_reg;

    logic signed [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     last_reg;
    logic                     first_reg;
    logic                     dz_reg;
    logic                     zero_reg;
    logic                     neg_reg;
    logic signed [WIDE_W-1:0] t_reg;
    logic signed [WIDE_W-1:0] sn_reg;
    logic [WIDE_W-1:0]        mag_reg;
    logic [WIDE_W-1:0]        wden_reg;
    logic [WIDE_W-1:0]        rn_reg;
    logic [WIDE_W-1:0]        rd_reg;

    logic                     accept;
    logic                     commit;
    logic                     slot_free;
    logic signed [NUM_W-1:0]  mul_a;
    logic signed [NUM_W-1:0]  mul_b;
    logic signed [WIDE_W-1:0] mul_p;
    logic signed [NUM_W-1:0]  acc_num_ext;
    logic signed [NUM_W-1:0]  acc_den_ext;
    logic signed [NUM_W-1:0]  den_ext;
    logic signed [WIDE_W-1:0] num_wide;
    logic                     gcd_start;
    logic                     gcd_done;
    logic [WIDE_W-1:0]        gcd_g;
    logic                     div_start;
    logic                     div_done;
    logic [WIDE_W-1:0]        div_q;
    logic [WIDE_W-1:0]        div_dividend;
    logic [WIDE_W-1:0]        rn_signed;
    logic                     range_bad;
    logic                     ovf;
    logic signed [VALUE_WIDTH-1:0] acc_num_next;
    logic [VALUE_WIDTH-2:0]        acc_den_next;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == S_DONE) && slot_free;

    assign out_valid       = out_valid_reg;
    assign sum_numerator   = out_num_reg;
    assign sum_denominator = out_den_reg;
    assign overflow        = out_ovf_reg;
    assign is_final        = out_final_reg;

    assign acc_num_ext = NUM_W'(acc_num_reg);
    assign acc_den_ext = $signed(NUM_W'(acc_den_reg));
    assign den_ext     = $signed({1'b0, den_reg});
    assign num_wide    = WIDE_W'(addend_numerator);

    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_a = acc_num_ext;
                mul_b = den_ext;
            end
            S_MUL2:
            begin
                mul_a = num_reg;
                mul_b = acc_den_ext;
            end
            S_MUL3:
            begin
                mul_a = acc_den_ext;
                mul_b = den_ext;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rsa_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    assign gcd_start = (state_reg == S_GO);

    rsa_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .val_a (mag_reg),
        .val_b (wden_reg),
        .done  (gcd_done),
        .gcd   (gcd_g)
    );

    // numerator divide follows the gcd, denominator divide follows that
    assign div_start    = ((state_reg == S_GCD) && gcd_done) ||
                          ((state_reg == S_DIVN) && div_done);
    assign div_dividend = (state_reg == S_GCD) ? mag_reg : wden_reg;

    rsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_q)
    );

    // range check and the value stored back into the sum
    assign rn_signed = neg_reg ? (WIDE_W'(0) - rn_reg) : rn_reg;
    assign range_bad = (rd_reg > LIM_MAX) || (neg_reg ? (rn_reg > LIM) : (rn_reg > LIM_MAX));
    assign ovf       = dz_reg || (!zero_reg && range_bad);

    always_comb
    begin
        if (zero_reg && !dz_reg)
        begin
            acc_num_next = '0;
            acc_den_next = (VALUE_WIDTH-1)'(1);
        end
        else if (ovf)
        begin
            if (first_reg)
            begin
                acc_num_next = '0;
                acc_den_next = (VALUE_WIDTH-1)'(1);
            end
            else
            begin
                acc_num_next = acc_num_reg;
                acc_den_next = acc_den_reg;
            end
        end
        else
        begin
            acc_num_next = rn_signed[VALUE_WIDTH-1:0];
            acc_den_next = rd_reg[VALUE_WIDTH-2:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (addend_denominator == '0)
                        state_next = S_DONE;
                    else if (!list_started_reg)
                        state_next = (addend_numerator == '0) ? S_DONE : S_GO;
                    else
                        state_next = S_MUL1;
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_MUL3;
            S_MUL3: state_next = S_MAG;
            S_MAG:  state_next = (t_reg == sn_reg && sn_reg == '0) ? S_DONE : S_GO;
            S_GO:   state_next = S_GCD;
            S_GCD:
            begin
                if (gcd_done)
                    state_next = S_DIVN;
            end
            S_DIVN:
            begin
                if (div_done)
                    state_next = S_DIVD;
            end
            S_DIVD:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            acc_num_reg      <= '0;
            acc_den_reg      <= (VALUE_WIDTH-1)'(1);
            list_started_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                list_started_reg <= 1'b1;
            if (commit)
            begin
                acc_num_reg   <= acc_num_next;
                acc_den_reg   <= acc_den_next;
                out_valid_reg <= 1'b1;
                if (last_reg)
                    list_started_reg <= 1'b0;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            num_reg   <= addend_numerator;
            den_reg   <= addend_denominator;
            last_reg  <= last_element;
            first_reg <= !list_started_reg;
            dz_reg    <= (addend_denominator == '0);
            zero_reg  <= !list_started_reg && (addend_denominator != '0) &&
                         (addend_numerator == '0);
            // first element of a list is reduced on its own
            if (!list_started_reg && addend_denominator != '0)
            begin
                neg_reg  <= addend_numerator[NUM_W-1];
                mag_reg  <= addend_numerator[NUM_W-1] ? (WIDE_W'(0) - num_wide) : num_wide;
                wden_reg <= WIDE_W'(addend_denominator);
            end
        end
        case (state_reg)
            S_MUL2:
            begin
                t_reg <= mul_p;
            end
            S_MUL3:
            begin
                sn_reg <= t_reg + mul_p;
                t_reg  <= '0;
            end
            S_MAG:
            begin
                wden_reg <= mul_p;
                neg_reg  <= sn_reg[WIDE_W-1];
                zero_reg <= (sn_reg == '0);
                mag_reg  <= sn_reg[WIDE_W-1] ? (WIDE_W'(0) - sn_reg) : sn_reg;
            end
            S_DIVN:
            begin
                if (div_done)
                    rn_reg <= div_q;
            end
            S_DIVD:
            begin
                if (div_done)
                    rd_reg <= div_q;
            end
            default:
            begin
                rd_reg <= rd_reg;
            end
        endcase
        if (commit)
        begin
            out_num_reg   <= NUM_W'(acc_num_next);
            out_den_reg   <= DEN_W'(acc_den_next);
            out_ovf_reg   <= ovf;
            out_final_reg <= last_reg;
        end
    end

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sum_denominator != '0))
        else $error("result transfer with zero denominator");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD && gcd_done) |-> (gcd_g != '0))
        else $error("gcd unit returned zero");

    a_list_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && last_reg) |=> !list_started_reg)
        else $error("list still open after final element");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("result not registered after commit");

endmodule

// ===== rtl/rsa_mul.sv =====
// shared signed multiplier with registered product
module rsa_mul
    import rsa_pkg::*;
(
    input  logic                     clk,
    input  logic signed [NUM_W-1:0]  op_a,
    input  logic signed [NUM_W-1:0]  op_b,
    output logic signed [WIDE_W-1:0] product
);

    logic signed [WIDE_W-1:0] prod;
    logic signed [WIDE_W-1:0] product_reg;

    assign prod    = op_a * op_b;
    assign product = product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= prod;
    end

endmodule

// ===== rtl/rsa_gcd.sv =====
// iterative binary gcd over the wide sum, one shift or subtract per cycle
module rsa_gcd
    import rsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] val_a,
    input  logic [WIDE_W-1:0] val_b,
    output logic              done,
    output logic [WIDE_W-1:0] gcd
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_PAIR = 3'd1;
    localparam logic [2:0] P_XODD = 3'd2;
    localparam logic [2:0] P_MAIN = 3'd3;
    localparam logic [2:0] P_OUT  = 3'd4;

    logic [2:0]         phase_reg;
    logic               done_reg;
    logic [WIDE_W-1:0]  x_reg;
    logic [WIDE_W-1:0]  y_reg;
    logic [SHIFT_W-1:0] k_reg;
    logic [WIDE_W-1:0]  g_reg;

    assign done = done_reg;
    assign gcd  = g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == P_OUT);
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        if (val_a == '0 || val_b == '0)
                            phase_reg <= P_OUT;
                        else
                            phase_reg <= P_PAIR;
                    end
                end
                P_PAIR:
                begin
                    if (x_reg[0] | y_reg[0])
                        phase_reg <= P_XODD;
                end
                P_XODD:
                begin
                    if (x_reg[0])
                        phase_reg <= P_MAIN;
                end
                P_MAIN:
                begin
                    if (y_reg == '0)
                        phase_reg <= P_OUT;
                end
                P_OUT:
                begin
                    phase_reg <= P_IDLE;
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    k_reg <= '0;
                    y_reg <= val_b;
                    // a zero operand leaves the other one as the gcd
                    x_reg <= (val_a == '0) ? val_b : val_a;
                end
            end
            P_PAIR:
            begin
                if (!(x_reg[0] | y_reg[0]))
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
            end
            P_XODD:
            begin
                if (!x_reg[0])
                    x_reg <= x_reg >> 1;
            end
            P_MAIN:
            begin
                if (y_reg != '0)
                begin
                    if (!y_reg[0])
                        y_reg <= y_reg >> 1;
                    else if (x_reg > y_reg)
                    begin
                        x_reg <= y_reg;
                        y_reg <= x_reg - y_reg;
                    end
                    else
                        y_reg <= y_reg - x_reg;
                end
            end
            P_OUT:
            begin
                g_reg <= x_reg << k_reg;
            end
            default:
            begin
                g_reg <= g_reg;
            end
        endcase
    end

endmodule

// ===== rtl/rsa_div.sv =====
// restoring divider, one quotient bit per cycle
module rsa_div
    import rsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] dividend,
    input  logic [WIDE_W-1:0] divisor,
    output logic              done,
    output logic [WIDE_W-1:0] quotient
);

    logic               busy_reg;
    logic               done_reg;
    logic [SHIFT_W-1:0] cnt_reg;
    logic [WIDE_W-1:0]  rem_reg;
    logic [WIDE_W-1:0]  quo_reg;
    logic [WIDE_W-1:0]  dvs_reg;
    logic [WIDE_W:0]    trial;

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign trial    = {rem_reg, quo_reg[WIDE_W-1]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == SHIFT_W'(WIDE_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SHIFT_W'(WIDE_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDE_W])
            begin
                rem_reg <= trial[WIDE_W-1:0];
                quo_reg <= {quo_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[WIDE_W-2:0], quo_reg[WIDE_W-1]};
                quo_reg <= {quo_reg[WIDE_W-2:0], 1'b0};
            end
        end
    end

endmodule
